/* hw/rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, quiet while reset is high
`define FC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// concurrent check that also runs through reset
`define FC_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* hw/rtl/fir_circ_pkg.sv */
package fir_circ_pkg;

   localparam int MAX_TAPS       = 64;
   localparam int SAMPLE_BITS    = 16;
   localparam int COEFF_BITS     = 16;
   localparam int MODE_BITS      = 2;
   localparam int COEFF_IDX_BITS = 6;
   localparam int TAP_CFG_BITS   = 7;

   localparam int IDX_W     = $clog2(MAX_TAPS);
   localparam int TAPS_W    = $clog2(MAX_TAPS + 1);
   localparam int PROD_W    = SAMPLE_BITS + COEFF_BITS;
   localparam int ACC_W     = PROD_W + IDX_W + 1;
   localparam int FRAC_BITS = COEFF_BITS - 1;
   localparam int RND_W     = ACC_W - FRAC_BITS;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [CSR_IDX_W-1:0] REG_TAP_COUNT = '0;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   typedef enum logic [MODE_BITS-1:0] {
      MODE_FILTER = 2'd0,
      MODE_COEFF  = 2'd1,
      MODE_CLEAR  = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                    wr;
      logic [TAP_CFG_BITS-1:0] tap_count;
   } csr_wr_type;

   typedef struct packed {
      logic issue;
      logic first;
      logic last;
   } mac_cmd_type;

   typedef struct packed {
      logic                          done;
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          clipped;
   } mac_res_type;

endpackage

/* hw/rtl/fir_circ_if.sv */
interface fir_circ_req_if;
   logic                                         valid;
   logic                                         ready;
   logic [fir_circ_pkg::MODE_BITS-1:0]           mode;
   logic signed [fir_circ_pkg::SAMPLE_BITS-1:0]  sample_in;
   logic [fir_circ_pkg::COEFF_IDX_BITS-1:0]      coeff_index;
   logic signed [fir_circ_pkg::COEFF_BITS-1:0]   coeff_value;

   modport source (output valid, mode, sample_in, coeff_index, coeff_value, input ready);
   modport sink (input valid, mode, sample_in, coeff_index, coeff_value, output ready);
endinterface

interface fir_circ_rsp_if;
   logic                                         valid;
   logic                                         ready;
   logic signed [fir_circ_pkg::SAMPLE_BITS-1:0]  sample_out;
   logic                                         clipped;

   modport source (output valid, sample_out, clipped, input ready);
   modport sink (input valid, sample_out, clipped, output ready);
endinterface

/* hw/rtl/fir_circ_ram.sv */
module fir_circ_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/fir_circ_csr.sv */
module fir_circ_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [fir_circ_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [fir_circ_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [fir_circ_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                  pready,
   output fir_circ_pkg::csr_wr_type              cfg
);

   logic [fir_circ_pkg::TAP_CFG_BITS-1:0] tap_count_ff, tap_count_in;
   logic                                  reg_hit;
   logic                                  wr_hit;

   assign pready  = 1'b1;
   assign reg_hit = (paddr[fir_circ_pkg::CSR_ADDR_W-1:2] == fir_circ_pkg::REG_TAP_COUNT);
   assign wr_hit  = psel && penable && pwrite && pready && reg_hit;

   always_comb begin
      tap_count_in = tap_count_ff;
      if (wr_hit) begin
         tap_count_in = pwdata[fir_circ_pkg::TAP_CFG_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= '0;
      end else begin
         tap_count_ff <= tap_count_in;
      end
   end

   assign prdata = reg_hit ? fir_circ_pkg::CSR_DATA_W'(tap_count_ff) : '0;

   assign cfg.wr        = wr_hit;
   assign cfg.tap_count = tap_count_ff;

endmodule

/* hw/rtl/fir_circ_mac.sv */
module fir_circ_mac (
   input  logic                                        clock,
   input  logic                                        reset,
   input  fir_circ_pkg::mac_cmd_type                   cmd,
   input  logic signed [fir_circ_pkg::COEFF_BITS-1:0]  coef,
   input  logic signed [fir_circ_pkg::SAMPLE_BITS-1:0] samp,
   output fir_circ_pkg::mac_res_type                   res
);

   fir_circ_pkg::mac_cmd_type s1_ff, p_cmd_ff;

   logic signed [fir_circ_pkg::PROD_W-1:0]      prod_ff;
   logic signed [fir_circ_pkg::ACC_W-1:0]       acc_ff;
   logic                                        acc_last_ff;
   logic signed [fir_circ_pkg::ACC_W-1:0]       acc_b;
   logic signed [fir_circ_pkg::RND_W-1:0]       rnd;
   logic signed [fir_circ_pkg::SAMPLE_BITS-1:0] sat;
   logic                                        clip;
   logic signed [fir_circ_pkg::SAMPLE_BITS-1:0] res_sample_ff;
   logic                                        res_clip_ff;
   logic                                        done_ff;

   // round half up, then floor shift
   always_comb begin
      acc_b = acc_ff + (fir_circ_pkg::ACC_W'(1) <<< (fir_circ_pkg::FRAC_BITS - 1));
      rnd   = signed'(acc_b[fir_circ_pkg::ACC_W-1:fir_circ_pkg::FRAC_BITS]);
      sat   = rnd[fir_circ_pkg::SAMPLE_BITS-1:0];
      clip  = 1'b0;
      if (rnd > fir_circ_pkg::RND_W'(fir_circ_pkg::SAMPLE_MAX)) begin
         sat  = fir_circ_pkg::SAMPLE_MAX;
         clip = 1'b1;
      end else if (rnd < fir_circ_pkg::RND_W'(fir_circ_pkg::SAMPLE_MIN)) begin
         sat  = fir_circ_pkg::SAMPLE_MIN;
         clip = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff       <= '0;
         p_cmd_ff    <= '0;
         acc_last_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         s1_ff       <= cmd;
         p_cmd_ff    <= s1_ff;
         acc_last_ff <= p_cmd_ff.issue && p_cmd_ff.last;
         done_ff     <= acc_last_ff;
      end
   end

   // ram data lines up with s1
   always_ff @(posedge clock) begin
      if (s1_ff.issue) begin
         prod_ff <= coef * samp;
      end
      if (p_cmd_ff.issue) begin
         if (p_cmd_ff.first) begin
            acc_ff <= fir_circ_pkg::ACC_W'(prod_ff);
         end else begin
            acc_ff <= acc_ff + fir_circ_pkg::ACC_W'(prod_ff);
         end
      end
      if (acc_last_ff) begin
         res_sample_ff <= sat;
         res_clip_ff   <= clip;
      end
   end

   assign res.done    = done_ff;
   assign res.sample  = res_sample_ff;
   assign res.clipped = res_clip_ff;

endmodule

/* hw/rtl/fir_circ_ctrl.sv */
module fir_circ_ctrl (
   input  logic                                         clock,
   input  logic                                         reset,
   fir_circ_req_if.sink                                 req,
   fir_circ_rsp_if.source                               rsp,
   input  fir_circ_pkg::csr_wr_type                     cfg,
   output fir_circ_pkg::mac_cmd_type                    cmd,
   output logic signed [fir_circ_pkg::COEFF_BITS-1:0]   coef,
   output logic signed [fir_circ_pkg::SAMPLE_BITS-1:0]  samp,
   input  fir_circ_pkg::mac_res_type                    res
);

   fir_circ_pkg::state_type state_ff, state_in;

   logic [fir_circ_pkg::IDX_W-1:0]              write_pos_ff, write_pos_in;
   logic [fir_circ_pkg::IDX_W-1:0]              cnt_ff, cnt_in;
   logic [fir_circ_pkg::IDX_W-1:0]              pos_ff, pos_in;
   logic [fir_circ_pkg::MAX_TAPS-1:0]           hist_vld_ff, hist_vld_in;
   logic                                        hvld_rd_ff;
   logic                                        pass_ff, pass_in;
   logic signed [fir_circ_pkg::SAMPLE_BITS-1:0] item_sample_ff, item_sample_in;
   logic                                        out_vld_ff, out_vld_in;
   logic signed [fir_circ_pkg::SAMPLE_BITS-1:0] out_sample_ff, out_sample_in;
   logic                                        out_clip_ff, out_clip_in;

   logic [fir_circ_pkg::TAPS_W-1:0]             taps;
   logic [fir_circ_pkg::IDX_W-1:0]              wp_start;
   logic [fir_circ_pkg::IDX_W-1:0]              wp_next;
   logic [fir_circ_pkg::IDX_W-1:0]              pos_dec;
   logic                                        last;
   logic                                        accept;

   logic                                        hist_we;
   logic                                        coef_we;
   logic [fir_circ_pkg::SAMPLE_BITS-1:0]        hist_q;
   logic [fir_circ_pkg::COEFF_BITS-1:0]         coef_q;

   fir_circ_ram #(
      .DEPTH(fir_circ_pkg::MAX_TAPS),
      .WIDTH(fir_circ_pkg::SAMPLE_BITS)
   ) u_hist_ram (
      .clock(clock),
      .we   (hist_we),
      .waddr(wp_start),
      .wdata(req.sample_in),
      .raddr(pos_ff),
      .rdata(hist_q)
   );

   fir_circ_ram #(
      .DEPTH(fir_circ_pkg::MAX_TAPS),
      .WIDTH(fir_circ_pkg::COEFF_BITS)
   ) u_coef_ram (
      .clock(clock),
      .we   (coef_we),
      .waddr(fir_circ_pkg::IDX_W'(req.coeff_index)),
      .wdata(req.coeff_value),
      .raddr(cnt_ff),
      .rdata(coef_q)
   );

   assign req.ready = (state_ff == fir_circ_pkg::ST_IDLE);
   assign accept    = req.valid && req.ready;

   always_comb begin
      if (32'(cfg.tap_count) > fir_circ_pkg::MAX_TAPS) begin
         taps = fir_circ_pkg::TAPS_W'(fir_circ_pkg::MAX_TAPS);
      end else begin
         taps = fir_circ_pkg::TAPS_W'(cfg.tap_count);
      end
   end

   // a stale pointer outside the tap window restarts at zero
   assign wp_start = (fir_circ_pkg::TAPS_W'(write_pos_ff) >= taps) ? '0 : write_pos_ff;
   assign wp_next  = (fir_circ_pkg::TAPS_W'(wp_start) + fir_circ_pkg::TAPS_W'(1) >= taps)
                     ? '0 : wp_start + fir_circ_pkg::IDX_W'(1);
   assign pos_dec  = (pos_ff == '0) ? fir_circ_pkg::IDX_W'(taps - fir_circ_pkg::TAPS_W'(1))
                     : pos_ff - fir_circ_pkg::IDX_W'(1);
   assign last     = (fir_circ_pkg::TAPS_W'(cnt_ff) + fir_circ_pkg::TAPS_W'(1) == taps);

   always_comb begin
      state_in       = state_ff;
      write_pos_in   = write_pos_ff;
      cnt_in         = cnt_ff;
      pos_in         = pos_ff;
      hist_vld_in    = hist_vld_ff;
      pass_in        = pass_ff;
      item_sample_in = item_sample_ff;
      out_vld_in     = out_vld_ff;
      out_sample_in  = out_sample_ff;
      out_clip_in    = out_clip_ff;
      hist_we        = 1'b0;
      coef_we        = 1'b0;
      cmd            = '0;

      if (cfg.wr) begin
         write_pos_in = '0;
      end
      if (rsp.ready) begin
         out_vld_in = 1'b0;
      end

      case (state_ff)
         fir_circ_pkg::ST_IDLE: begin
            if (accept) begin
               case (req.mode)
                  fir_circ_pkg::MODE_FILTER: begin
                     item_sample_in = req.sample_in;
                     if (taps == '0) begin
                        pass_in  = 1'b1;
                        state_in = fir_circ_pkg::ST_EMIT;
                     end else begin
                        pass_in               = 1'b0;
                        hist_we               = 1'b1;
                        hist_vld_in[wp_start] = 1'b1;
                        pos_in                = wp_start;
                        cnt_in                = '0;
                        write_pos_in          = wp_next;
                        state_in              = fir_circ_pkg::ST_RUN;
                     end
                  end
                  fir_circ_pkg::MODE_COEFF: begin
                     coef_we = (32'(req.coeff_index) < fir_circ_pkg::MAX_TAPS);
                  end
                  fir_circ_pkg::MODE_CLEAR: begin
                     hist_vld_in  = '0;
                     write_pos_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         fir_circ_pkg::ST_RUN: begin
            cmd.issue = 1'b1;
            cmd.first = (cnt_ff == '0);
            cmd.last  = last;
            cnt_in    = cnt_ff + fir_circ_pkg::IDX_W'(1);
            pos_in    = pos_dec;
            if (last) begin
               state_in = fir_circ_pkg::ST_DRAIN;
            end
         end
         fir_circ_pkg::ST_DRAIN: begin
            if (res.done) begin
               state_in = fir_circ_pkg::ST_EMIT;
            end
         end
         fir_circ_pkg::ST_EMIT: begin
            if (!out_vld_ff || rsp.ready) begin
               out_vld_in    = 1'b1;
               out_sample_in = pass_ff ? item_sample_ff : res.sample;
               out_clip_in   = pass_ff ? 1'b0 : res.clipped;
               state_in      = fir_circ_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fir_circ_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fir_circ_pkg::ST_IDLE;
         write_pos_ff <= '0;
         hist_vld_ff  <= '0;
         out_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         write_pos_ff <= write_pos_in;
         hist_vld_ff  <= hist_vld_in;
         out_vld_ff   <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff         <= cnt_in;
      pos_ff         <= pos_in;
      pass_ff        <= pass_in;
      item_sample_ff <= item_sample_in;
      out_sample_ff  <= out_sample_in;
      out_clip_ff    <= out_clip_in;
      hvld_rd_ff     <= hist_vld_ff[pos_ff];
   end

   // history entries cleared since reset or clear read as zero
   assign coef = coef_q;
   assign samp = hvld_rd_ff ? hist_q : '0;

   assign rsp.valid      = out_vld_ff;
   assign rsp.sample_out = out_sample_ff;
   assign rsp.clipped    = out_clip_ff;

endmodule

/* hw/rtl/fir_filter_circular_top.sv */
// Programmable FIR filter with a circular delay line of up to 64 taps.
// req_ch carries one item per transfer: mode 0 filters sample_in, mode 1
// writes coeff_value into slot coeff_index, mode 2 clears the delay line and
// the write pointer, mode 3 is ignored. Only mode 0 yields a transfer on
// rsp_ch (sample_out, clipped), in the order the items came in.
// Register tap_count at byte address 0 (APB, write in setup + access cycles)
// sets the taps in use, values above 64 act as 64; a write also resets the
// write pointer. Zero taps pass samples straight through.
// A filtered sample is written to the delay line, then runs one
// multiply-accumulate per tap through the coefficient and history memories
// and drains from the MAC pipeline into the output register; a passed-through
// one goes straight to that register. Coefficient and clear items leave the
// block idle. Items are worked one at a time: the next item is taken only once
// the last filtered or passed-through one has reached the output register.
// Reset clears the tap count, write pointer, delay line and result valid flag;
// coefficients must be written before use.
// A result waits in its output register while rsp_ch is stalled; the next
// item is still taken and runs until its own result needs that register.
module fir_filter_circular_top (
   input  logic                                  clock,
   input  logic                                  reset,
   fir_circ_req_if.sink                          req_ch,
   fir_circ_rsp_if.source                        rsp_ch,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [fir_circ_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [fir_circ_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [fir_circ_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                  pready
);

   fir_circ_pkg::csr_wr_type                    cfg;
   fir_circ_pkg::mac_cmd_type                   cmd;
   fir_circ_pkg::mac_res_type                   res;
   logic signed [fir_circ_pkg::COEFF_BITS-1:0]  coef;
   logic signed [fir_circ_pkg::SAMPLE_BITS-1:0] samp;

   fir_circ_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .psel   (psel),
      .penable(penable),
      .pwrite (pwrite),
      .paddr  (paddr),
      .pwdata (pwdata),
      .prdata (prdata),
      .pready (pready),
      .cfg    (cfg)
   );

   fir_circ_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch),
      .cfg  (cfg),
      .cmd  (cmd),
      .coef (coef),
      .samp (samp),
      .res  (res)
   );

   fir_circ_mac u_mac (
      .clock(clock),
      .reset(reset),
      .cmd  (cmd),
      .coef (coef),
      .samp (samp),
      .res  (res)
   );

endmodule

/* hw/rtl/fir_circ_chk.sv */
`include "assert_macros.svh"

module fir_circ_chk (
   input logic                                        clock,
   input logic                                        reset,
   input logic                                        req_valid,
   input logic                                        req_ready,
   input logic [fir_circ_pkg::MODE_BITS-1:0]          req_mode,
   input logic                                        rsp_valid,
   input logic                                        rsp_ready,
   input logic signed [fir_circ_pkg::SAMPLE_BITS-1:0] rsp_sample_out,
   input logic                                        rsp_clipped
);

   `FC_ASSERT_RST(a_reset_state, reset |=> (req_ready && !rsp_valid), "bad state after reset")

   `FC_ASSERT(a_filter_busy, (req_valid && req_ready && req_mode == fir_circ_pkg::MODE_FILTER) |=> !req_ready, "ready right after filter item")

   `FC_ASSERT(a_rsp_from_work, $rose(rsp_valid) |-> !$past(req_ready), "result appeared while idle")

   `FC_ASSERT(a_clip_value, (rsp_valid && rsp_clipped) |-> (rsp_sample_out == fir_circ_pkg::SAMPLE_MAX || rsp_sample_out == fir_circ_pkg::SAMPLE_MIN), "clipped result not at a rail")

   `FC_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_sample_out) && $stable(rsp_clipped)), "stalled result changed")

endmodule

bind fir_filter_circular_top fir_circ_chk u_chk (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .req_mode      (req_ch.mode),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_sample_out(rsp_ch.sample_out),
   .rsp_clipped   (rsp_ch.clipped)
);

/* dv/fir_filter_circular_top_test.sv */
`timescale 1ns / 1ps

module fir_filter_circular_top_test;

   localparam logic [fir_circ_pkg::MODE_BITS-1:0] MODE_UNUSED = 2'd3;
   localparam logic [fir_circ_pkg::CSR_IDX_W-1:0] REG_UNMAPPED =
      fir_circ_pkg::CSR_IDX_W'(1);
   localparam logic signed [fir_circ_pkg::COEFF_BITS-1:0] COEFF_MIN =
      {1'b1, {(fir_circ_pkg::COEFF_BITS-1){1'b0}}};
   localparam logic signed [fir_circ_pkg::COEFF_BITS-1:0] COEFF_MAX =
      {1'b0, {(fir_circ_pkg::COEFF_BITS-1){1'b1}}};
   localparam logic signed [fir_circ_pkg::COEFF_BITS-1:0] COEFF_HALF =
      fir_circ_pkg::COEFF_BITS'(16384);
   localparam int SETTLE_CYCLES = fir_circ_pkg::MAX_TAPS + 16;
   localparam int STALL_LIMIT = 4000;
   localparam int TARGET_ITEMS = 1350;

   typedef struct {
      logic signed [fir_circ_pkg::SAMPLE_BITS-1:0] sample;
      logic                                        clipped;
   } filtered_type;

   class filter_scoreboard;
      logic signed [fir_circ_pkg::SAMPLE_BITS-1:0] delay_line[fir_circ_pkg::MAX_TAPS];
      logic signed [fir_circ_pkg::COEFF_BITS-1:0]  coeffs[fir_circ_pkg::MAX_TAPS];
      int unsigned                                 wr_ptr;
      int unsigned                                 tap_cfg;
      filtered_type                                expected_outputs[$];
      int                                          errors;

      function new();
         foreach (delay_line[i]) delay_line[i] = '0;
         foreach (coeffs[i]) coeffs[i] = '0;
         wr_ptr = 0;
         tap_cfg = 0;
         errors = 0;
      endfunction

      function void set_taps(logic [fir_circ_pkg::TAP_CFG_BITS-1:0] value);
         tap_cfg = 32'(value);
         wr_ptr = 0;
      endfunction

      function int pending();
         return expected_outputs.size();
      endfunction

      function void filter_sample(logic signed [fir_circ_pkg::SAMPLE_BITS-1:0] sample);
         int unsigned  taps;
         int unsigned  pos;
         longint       acc;
         longint       rounded;
         filtered_type res;
         taps = (tap_cfg > fir_circ_pkg::MAX_TAPS) ? fir_circ_pkg::MAX_TAPS : tap_cfg;
         res.sample = sample;
         res.clipped = 1'b0;
         if (taps != 0) begin
            // pointer left out of range is taken as the first slot
            if (wr_ptr >= taps) wr_ptr = 0;
            delay_line[wr_ptr] = sample;
            pos = wr_ptr;
            acc = 0;
            for (int j = 0; j < taps; j++) begin
               acc += longint'(coeffs[j]) * longint'(delay_line[pos]);
               pos = (pos == 0) ? taps - 1 : pos - 1;
            end
            // floor of (sum + half lsb), so ties go up
            rounded = (acc + 64'sd16384) >>> 15;
            if (rounded > longint'(fir_circ_pkg::SAMPLE_MAX)) begin
               rounded = longint'(fir_circ_pkg::SAMPLE_MAX);
               res.clipped = 1'b1;
            end else if (rounded < longint'(fir_circ_pkg::SAMPLE_MIN)) begin
               rounded = longint'(fir_circ_pkg::SAMPLE_MIN);
               res.clipped = 1'b1;
            end
            res.sample = rounded[fir_circ_pkg::SAMPLE_BITS-1:0];
            wr_ptr = (wr_ptr + 1 >= taps) ? 0 : wr_ptr + 1;
         end
         expected_outputs.insert(expected_outputs.size(), res);
      endfunction

      function void note_item(logic [fir_circ_pkg::MODE_BITS-1:0] mode,
                              logic signed [fir_circ_pkg::SAMPLE_BITS-1:0] sample,
                              logic [fir_circ_pkg::COEFF_IDX_BITS-1:0] idx,
                              logic signed [fir_circ_pkg::COEFF_BITS-1:0] value);
         case (mode)
            fir_circ_pkg::MODE_FILTER: filter_sample(sample);
            fir_circ_pkg::MODE_COEFF: coeffs[idx] = value;
            fir_circ_pkg::MODE_CLEAR: begin
               foreach (delay_line[i]) delay_line[i] = '0;
               wr_ptr = 0;
            end
            default: ;
         endcase
      endfunction

      function void check_result(logic signed [fir_circ_pkg::SAMPLE_BITS-1:0] sample_out,
                                 logic clipped);
         filtered_type exp_out;
         if (expected_outputs.size() == 0) begin
            $error("result with nothing expected: sample_out=%0d clipped=%0b",
                   sample_out, clipped);
            errors++;
            return;
         end
         exp_out = expected_outputs.pop_front();
         if (sample_out !== exp_out.sample) begin
            $error("sample_out mismatch: expected %0d, actual %0d", exp_out.sample, sample_out);
            errors++;
         end
         if (clipped !== exp_out.clipped) begin
            $error("clipped mismatch: expected %0b, actual %0b", exp_out.clipped, clipped);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [fir_circ_pkg::CSR_ADDR_W-1:0] paddr;
   logic [fir_circ_pkg::CSR_DATA_W-1:0] pwdata;
   logic [fir_circ_pkg::CSR_DATA_W-1:0] prdata;
   logic pready;

   fir_circ_req_if req_if();
   fir_circ_rsp_if rsp_if();

   filter_scoreboard sb;
   bit no_gaps;
   int items_sent;
   int quiet_cycles;

   fir_filter_circular_top DUT (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_if),
      .rsp_ch  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_if.ready <= no_gaps || ($urandom_range(0, 99) >= 16);
   end

   // results are checked before the input of the same edge is noted
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.sample_out, rsp_if.clipped);
         if (req_if.valid && req_if.ready)
            sb.note_item(req_if.mode, req_if.sample_in, req_if.coeff_index, req_if.coeff_value);
         if ((rsp_if.valid && rsp_if.ready) || (req_if.valid && req_if.ready)
             || (psel && penable && pwrite && pready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   task automatic send_item(input logic [fir_circ_pkg::MODE_BITS-1:0] mode,
                            input logic signed [fir_circ_pkg::SAMPLE_BITS-1:0] sample,
                            input logic [fir_circ_pkg::COEFF_IDX_BITS-1:0] idx,
                            input logic signed [fir_circ_pkg::COEFF_BITS-1:0] value);
      @(negedge clock);
      while (!no_gaps && $urandom_range(0, 99) < 16) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.mode <= mode;
      req_if.sample_in <= sample;
      req_if.coeff_index <= idx;
      req_if.coeff_value <= value;
      do @(posedge clock); while (!req_if.ready);
      if (mode != MODE_UNUSED) items_sent++;
   endtask

   task automatic send_sample(input logic signed [fir_circ_pkg::SAMPLE_BITS-1:0] sample);
      send_item(fir_circ_pkg::MODE_FILTER, sample,
                fir_circ_pkg::COEFF_IDX_BITS'($urandom_range(0, 63)),
                fir_circ_pkg::COEFF_BITS'($urandom));
   endtask

   task automatic send_coeff(input logic [fir_circ_pkg::COEFF_IDX_BITS-1:0] idx,
                             input logic signed [fir_circ_pkg::COEFF_BITS-1:0] value);
      send_item(fir_circ_pkg::MODE_COEFF, fir_circ_pkg::SAMPLE_BITS'($urandom), idx, value);
   endtask

   task automatic send_clear();
      send_item(fir_circ_pkg::MODE_CLEAR, fir_circ_pkg::SAMPLE_BITS'($urandom),
                fir_circ_pkg::COEFF_IDX_BITS'($urandom_range(0, 63)),
                fir_circ_pkg::COEFF_BITS'($urandom));
   endtask

   task automatic send_unused();
      send_item(MODE_UNUSED, fir_circ_pkg::SAMPLE_BITS'($urandom),
                fir_circ_pkg::COEFF_IDX_BITS'($urandom_range(0, 63)),
                fir_circ_pkg::COEFF_BITS'($urandom));
   endtask

   // stop sending and let the filter finish everything in flight
   task automatic drain_results();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [fir_circ_pkg::CSR_IDX_W-1:0] reg_idx,
                            input logic [fir_circ_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {reg_idx, 2'b00};
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (reg_idx == fir_circ_pkg::REG_TAP_COUNT)
         sb.set_taps(data[fir_circ_pkg::TAP_CFG_BITS-1:0]);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_taps(input int taps);
      logic [fir_circ_pkg::CSR_DATA_W-1:0] word;
      word = $urandom;
      word[fir_circ_pkg::TAP_CFG_BITS-1:0] = fir_circ_pkg::TAP_CFG_BITS'(taps);
      write_csr(fir_circ_pkg::REG_TAP_COUNT, word);
   endtask

   function automatic logic signed [fir_circ_pkg::COEFF_BITS-1:0] pick_coeff(input int style);
      case (style)
         0: return fir_circ_pkg::COEFF_BITS'($urandom);
         1: return fir_circ_pkg::COEFF_BITS'(int'($urandom_range(0, 4095)) - 2048);
         default: return $urandom_range(0, 1) ? COEFF_MIN : COEFF_MAX;
      endcase
   endfunction

   function automatic logic signed [fir_circ_pkg::SAMPLE_BITS-1:0] pick_sample();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 10) return fir_circ_pkg::SAMPLE_MAX;
      if (r < 20) return fir_circ_pkg::SAMPLE_MIN;
      if (r < 30) return fir_circ_pkg::SAMPLE_BITS'(int'($urandom_range(0, 255)) - 128);
      return fir_circ_pkg::SAMPLE_BITS'($urandom);
   endfunction

   initial begin
      int phase;
      int taps_pick;
      int style;
      int unsigned r;
      sb = new();
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.mode = fir_circ_pkg::MODE_FILTER;
      req_if.sample_in = '0;
      req_if.coeff_index = '0;
      req_if.coeff_value = '0;
      rsp_if.ready = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      no_gaps = 1'b0;
      items_sent = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero taps: straight pass-through, no coefficients needed
      send_sample('0);
      send_sample(fir_circ_pkg::SAMPLE_MAX);
      send_sample(fir_circ_pkg::SAMPLE_MIN);
      send_sample(fir_circ_pkg::SAMPLE_BITS'(-1));
      send_unused();
      send_clear();
      send_sample(fir_circ_pkg::SAMPLE_BITS'(1));
      // every slot gets written before any tap reads it
      for (int j = 0; j < fir_circ_pkg::MAX_TAPS; j++)
         send_coeff(fir_circ_pkg::COEFF_IDX_BITS'(j), (j < 2) ? COEFF_MIN : pick_coeff(0));

      // single tap of -1.0: most negative sample saturates upward
      drain_results();
      set_taps(1);
      send_sample(fir_circ_pkg::SAMPLE_MIN);
      send_sample(fir_circ_pkg::SAMPLE_MAX);
      send_sample('0);
      // half coefficient exposes rounding of ties
      send_coeff('0, COEFF_HALF);
      send_sample(fir_circ_pkg::SAMPLE_BITS'(1));
      send_sample(fir_circ_pkg::SAMPLE_BITS'(-1));
      send_sample(fir_circ_pkg::SAMPLE_BITS'(3));
      send_sample(fir_circ_pkg::SAMPLE_BITS'(-3));

      // two taps of -1.0 on full-scale input saturate downward
      drain_results();
      set_taps(2);
      send_coeff('0, COEFF_MIN);
      send_sample(fir_circ_pkg::SAMPLE_MAX);
      send_sample(fir_circ_pkg::SAMPLE_MAX);
      send_clear();
      send_sample(fir_circ_pkg::SAMPLE_BITS'(5));

      // unmapped register must not disturb the pointer
      drain_results();
      write_csr(REG_UNMAPPED, '1);
      send_sample(fir_circ_pkg::SAMPLE_BITS'(7));

      // tap count beyond the delay line acts as full length
      drain_results();
      set_taps(127);
      send_sample(fir_circ_pkg::SAMPLE_MAX);
      send_sample(fir_circ_pkg::SAMPLE_MIN);

      phase = 0;
      while (items_sent < TARGET_ITEMS) begin
         drain_results();
         no_gaps = (phase >= 4 && phase < 7);
         r = $urandom_range(0, 99);
         if (r < 5) taps_pick = 0;
         else if (r < 12) taps_pick = fir_circ_pkg::MAX_TAPS;
         else if (r < 17) taps_pick = $urandom_range(fir_circ_pkg::MAX_TAPS + 1, 127);
         else if (r < 25) taps_pick = 1;
         else if (r < 60) taps_pick = $urandom_range(2, 12);
         else taps_pick = $urandom_range(13, fir_circ_pkg::MAX_TAPS - 1);
         set_taps(taps_pick);
         if ($urandom_range(0, 7) == 0) write_csr(REG_UNMAPPED, $urandom);
         style = $urandom_range(0, 2);
         if ($urandom_range(0, 1) == 1)
            for (int j = 0; j < taps_pick && j < fir_circ_pkg::MAX_TAPS; j++)
               send_coeff(fir_circ_pkg::COEFF_IDX_BITS'(j), pick_coeff(style));
         repeat ($urandom_range(20, 80)) begin
            r = $urandom_range(0, 99);
            if (r < 85) send_sample(pick_sample());
            else if (r < 93)
               send_coeff(fir_circ_pkg::COEFF_IDX_BITS'($urandom_range(0, 63)),
                          pick_coeff(style));
            else if (r < 96) send_clear();
            else send_unused();
         end
         phase++;
      end
      no_gaps = 1'b0;
      drain_results();

      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
